@@ hdl/bitmap_slot_allocator_defines.svh @@
// Assertion macros used by the checker of the slot allocator.
// No dependencies; take in by `include before the asserting module.
`ifndef BITMAP_SLOT_ALLOCATOR_DEFINES_SVH
`define BITMAP_SLOT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, off while reset is asserted
`define BSA_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted
`define BSA_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/bsa_pkg.sv @@
// Shared types and constants of the bitmap slot allocator.
// No dependencies; used by the word unit, the top level and the checker.
`default_nettype none

package bsa_pkg;

  // Field widths
  localparam int SLOT_W       = 14;
  localparam int SLOT_MAX     = 16383;
  localparam int KIND_W       = 2;
  localparam int STATUS_W     = 2;
  localparam int BLOCK_USED_W = 9;
  localparam int INODE_USED_W = 7;

  // Stream packing
  localparam int IN_TUSER_W  = 3;   // kind, pool
  localparam int IN_TDATA_W  = 16;  // index, pad
  localparam int OUT_TUSER_W = 2;   // status
  localparam int OUT_TDATA_W = 16;  // slot, is_set, pad

  // Configuration port
  localparam int CFG_AW = 1;
  localparam int CFG_DW = 9;
  localparam logic [CFG_AW-1:0] CFG_BLOCK_WORDS_USED = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_INODE_WORDS_USED = 1'd1;
  localparam logic [BLOCK_USED_W-1:0] BLOCK_USED_RST = 9'd256;
  localparam logic [INODE_USED_W-1:0] INODE_USED_RST = 7'd64;

  // Request kinds
  localparam logic [KIND_W-1:0] K_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] K_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] K_QUERY = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTSET = 2'd3;

  // Flags from the shared word unit
  typedef struct packed {
    logic full;
    logic bit_val;
  } word_flags_t;

endpackage

`default_nettype wire

@@ hdl/bsa_map_mem.sv @@
// One bitmap store: single write port, single read port, registered read data.
// No dependencies.
`default_nettype none

module bsa_map_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write one word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read one word a cycle, data lands on the next edge
  always_ff @(posedge clk) begin
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

@@ hdl/bsa_word_unit.sv @@
// Shared word unit: full test, lowest clear bit, bit test, bit set and clear.
// Depends on bsa_pkg for the flag struct.
`default_nettype none

module bsa_word_unit #(
  parameter int WORD_BITS = 64,
  localparam int BIW = $clog2(WORD_BITS)
) (
  input  wire logic [WORD_BITS-1:0] word_i,
  input  wire logic [BIW-1:0]       sel_i,
  output bsa_pkg::word_flags_t      flags_o,
  output logic      [BIW-1:0]       low_clear_o,
  output logic      [WORD_BITS-1:0] word_set_o,
  output logic      [WORD_BITS-1:0] word_clr_o
);

  logic [WORD_BITS-1:0] sel_mask;

  // Find the lowest clear bit; scan downward so the lowest wins
  always_comb begin
    low_clear_o = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word_i[i]) begin
        low_clear_o = BIW'(i);
      end
    end
  end

  assign sel_mask        = WORD_BITS'(1) << sel_i;
  assign flags_o.full    = &word_i;
  assign flags_o.bit_val = word_i[sel_i];
  assign word_set_o      = word_i | sel_mask;
  assign word_clr_o      = word_i & ~sel_mask;

endmodule

`default_nettype wire

@@ hdl/bitmap_slot_allocator.sv @@
// Top level of the bitmap slot allocator: sequencer, hints, config and stores.
// Depends on bsa_pkg, bsa_map_mem and bsa_word_unit.
//
//  channel   direction  fields (low bit up)                handshake
//  in_*      slave      tuser: kind, pool; tdata: index    tvalid/tready
//  out_*     master     tuser: status; tdata: slot, is_set tvalid/tready
//  cfg_*     write      addr: register, wdata: value       cfg_we, no wait
//
// Alloc passes DIV, then SCAN from the hint (one word per cycle through the word
// unit), SET at the first word with a clear bit, then RESP; if all are full the
// scan ends in RESP, and a hint at or past the words in use goes from DIV to RESP.
// Free and query pass DIV, SPLIT, TEST and RESP, an index out of range DIV, SPLIT
// and RESP, an unknown kind DIV and RESP; the next request is taken in the cycle
// after the result is loaded. After reset a clearing pass over max(BLOCK_WORDS,
// INODE_WORDS) words zeroes both bitmaps; in_tready stays low meanwhile, config
// writes are taken. One request is in flight at a time; a stalled result holds
// in the output register and the next request is taken while it waits.
`default_nettype none

module bitmap_slot_allocator #(
  parameter int WORD_BITS   = 64,
  parameter int BLOCK_WORDS = 256,
  parameter int INODE_WORDS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // kind [1:0], pool [2]
  input  wire logic [bsa_pkg::IN_TUSER_W-1:0]  in_tuser,
  // index [13:0], zero pad [15:14]
  input  wire logic [bsa_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // status [1:0]
  output logic      [bsa_pkg::OUT_TUSER_W-1:0] out_tuser,
  // slot [13:0], is_set [14], zero pad [15]
  output logic      [bsa_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic                            cfg_we,
  input  wire logic [bsa_pkg::CFG_AW-1:0]      cfg_addr,
  input  wire logic [bsa_pkg::CFG_DW-1:0]      cfg_wdata
);

  localparam int BAW  = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
  localparam int IAW  = (INODE_WORDS > 1) ? $clog2(INODE_WORDS) : 1;
  localparam int MAXD = (BLOCK_WORDS > INODE_WORDS) ? BLOCK_WORDS : INODE_WORDS;
  localparam int UW   = $clog2(MAXD + 1);
  localparam int CW   = (MAXD > 1) ? $clog2(MAXD) : 1;
  localparam int EW   = (UW > bsa_pkg::BLOCK_USED_W) ? UW : bsa_pkg::BLOCK_USED_W;
  localparam int BIW  = $clog2(WORD_BITS);
  localparam int SW   = bsa_pkg::SLOT_W;
  // Reciprocal for index / WORD_BITS, exact over every 14-bit index
  localparam int NSH   = SW + $clog2(WORD_BITS);
  localparam int RCW   = SW + 1;
  localparam int RECIP = ((1 << NSH) + WORD_BITS - 1) / WORD_BITS;
  localparam logic [RCW-1:0] RECIP_C = RCW'(RECIP);
  localparam int QW   = $clog2((bsa_pkg::SLOT_MAX / WORD_BITS) + 1);
  localparam int CMPW = (QW > UW) ? QW : UW;

  // Sequencer states
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_SPLIT = 4'd3;
  localparam logic [3:0] S_TEST  = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_SET   = 4'd6;
  localparam logic [3:0] S_RESP  = 4'd7;

  // Control state
  logic [3:0]                        state_r, state_nxt;
  logic [CW-1:0]                     clr_cnt_r, clr_cnt_nxt;
  logic [BAW-1:0]                    block_hint_r, block_hint_nxt;
  logic [IAW-1:0]                    inode_hint_r, inode_hint_nxt;
  logic [bsa_pkg::BLOCK_USED_W-1:0]  block_used_r;
  logic [bsa_pkg::INODE_USED_W-1:0]  inode_used_r;
  logic                              out_tvalid_r, out_tvalid_nxt;

  // Request and working payload
  logic [bsa_pkg::KIND_W-1:0]        kind_r, kind_nxt;
  logic                              pool_r, pool_nxt;
  logic [SW-1:0]                     idx_r, idx_nxt;
  logic [QW-1:0]                     q_r, q_nxt;
  logic [UW-1:0]                     w_r, w_nxt;
  logic [BIW-1:0]                    bit_r, bit_nxt;
  logic [WORD_BITS-1:0]              word_r, word_nxt;
  logic [bsa_pkg::STATUS_W-1:0]      status_r, status_nxt;
  logic [SW-1:0]                     slot_r, slot_nxt;
  logic                              is_set_r, is_set_nxt;
  logic [bsa_pkg::STATUS_W-1:0]      out_status_r, out_status_nxt;
  logic [SW-1:0]                     out_slot_r, out_slot_nxt;
  logic                              out_is_set_r, out_is_set_nxt;

  // Datapath nets
  logic [UW-1:0]                     used_blk, used_ino, used_sel, hint_sel, w_inc;
  logic [SW+RCW-1:0]                 prod_w;
  logic [SW-1:0]                     rem_w;
  logic [UW-1:0]                     rd_word;
  logic                              blk_we, ino_we;
  logic [BAW-1:0]                    blk_wa;
  logic [IAW-1:0]                    ino_wa;
  logic [WORD_BITS-1:0]              wr_data, blk_rd, ino_rd, rd_sel, uw_word;
  bsa_pkg::word_flags_t              uw_flags;
  logic [BIW-1:0]                    uw_low;
  logic [WORD_BITS-1:0]              uw_set, uw_clr;
  logic                              clr_last;

  // Clamp words in use to the store depth
  assign used_blk = (EW'(block_used_r) > EW'(BLOCK_WORDS)) ? UW'(BLOCK_WORDS)
                                                           : UW'(block_used_r);
  assign used_ino = (EW'(inode_used_r) > EW'(INODE_WORDS)) ? UW'(INODE_WORDS)
                                                           : UW'(inode_used_r);
  assign used_sel = pool_r ? used_ino : used_blk;
  assign hint_sel = pool_r ? UW'(inode_hint_r) : UW'(block_hint_r);
  assign w_inc    = w_r + UW'(1);
  assign rd_sel   = pool_r ? ino_rd : blk_rd;
  assign prod_w   = idx_r * RECIP_C;
  assign rem_w    = idx_r - SW'(q_r * WORD_BITS);
  assign clr_last = (clr_cnt_r == CW'(MAXD - 1));

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {1'b0, out_is_set_r, out_slot_r};

  // Bitmap stores
  bsa_map_mem #(.DEPTH(BLOCK_WORDS), .WIDTH(WORD_BITS)) u_block_map (
    .clk     (clk),
    .wr_en   (blk_we),
    .wr_addr (blk_wa),
    .wr_data (wr_data),
    .rd_addr (rd_word[BAW-1:0]),
    .rd_data (blk_rd)
  );

  bsa_map_mem #(.DEPTH(INODE_WORDS), .WIDTH(WORD_BITS)) u_inode_map (
    .clk     (clk),
    .wr_en   (ino_we),
    .wr_addr (ino_wa),
    .wr_data (wr_data),
    .rd_addr (rd_word[IAW-1:0]),
    .rd_data (ino_rd)
  );

  // Shared word unit
  bsa_word_unit #(.WORD_BITS(WORD_BITS)) u_word_unit (
    .word_i      (uw_word),
    .sel_i       (bit_r),
    .flags_o     (uw_flags),
    .low_clear_o (uw_low),
    .word_set_o  (uw_set),
    .word_clr_o  (uw_clr)
  );

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    block_hint_nxt = block_hint_r;
    inode_hint_nxt = inode_hint_r;
    kind_nxt       = kind_r;
    pool_nxt       = pool_r;
    idx_nxt        = idx_r;
    q_nxt          = q_r;
    w_nxt          = w_r;
    bit_nxt        = bit_r;
    word_nxt       = word_r;
    status_nxt     = status_r;
    slot_nxt       = slot_r;
    is_set_nxt     = is_set_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_is_set_nxt = out_is_set_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    rd_word        = w_r;
    uw_word        = rd_sel;
    blk_we         = 1'b0;
    ino_we         = 1'b0;
    blk_wa         = w_r[BAW-1:0];
    ino_wa         = w_r[IAW-1:0];
    wr_data        = uw_set;

    case (state_r)
      S_CLEAR: begin
        blk_we      = ({1'b0, clr_cnt_r} < (CW+1)'(BLOCK_WORDS));
        ino_we      = ({1'b0, clr_cnt_r} < (CW+1)'(INODE_WORDS));
        blk_wa      = clr_cnt_r[BAW-1:0];
        ino_wa      = clr_cnt_r[IAW-1:0];
        wr_data     = '0;
        clr_cnt_nxt = clr_cnt_r + CW'(1);
        if (clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        // Capture the request beat
        if (in_tvalid) begin
          kind_nxt  = in_tuser[1:0];
          pool_nxt  = in_tuser[2];
          idx_nxt   = in_tdata[SW-1:0];
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        slot_nxt   = '0;
        is_set_nxt = 1'b0;
        if (kind_r == bsa_pkg::K_ALLOC) begin
          // Start the scan at the hint, or report full if it is past the end
          rd_word = hint_sel;
          w_nxt   = hint_sel;
          if (hint_sel >= used_sel) begin
            status_nxt = bsa_pkg::ST_FULL;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_SCAN;
          end
        end else if (kind_r == bsa_pkg::K_FREE || kind_r == bsa_pkg::K_QUERY) begin
          q_nxt     = QW'(prod_w >> NSH);
          state_nxt = S_SPLIT;
        end else begin
          status_nxt = bsa_pkg::ST_RANGE;
          state_nxt  = S_RESP;
        end
      end
      S_SPLIT: begin
        // Word and bit of the index; fetch the word
        rd_word = UW'(q_r);
        w_nxt   = UW'(q_r);
        bit_nxt = BIW'(rem_w);
        if (CMPW'(q_r) >= CMPW'(used_sel)) begin
          status_nxt = bsa_pkg::ST_RANGE;
          state_nxt  = S_RESP;
        end else begin
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        state_nxt = S_RESP;
        if (kind_r == bsa_pkg::K_QUERY) begin
          status_nxt = bsa_pkg::ST_OK;
          is_set_nxt = uw_flags.bit_val;
        end else if (!uw_flags.bit_val) begin
          status_nxt = bsa_pkg::ST_NOTSET;
        end else begin
          // Clear the bit and lower the hint
          status_nxt = bsa_pkg::ST_OK;
          wr_data    = uw_clr;
          blk_we     = !pool_r;
          ino_we     = pool_r;
          if (w_r < hint_sel) begin
            if (pool_r) begin
              inode_hint_nxt = w_r[IAW-1:0];
            end else begin
              block_hint_nxt = w_r[BAW-1:0];
            end
          end
        end
      end
      S_SCAN: begin
        // Check the word on the read port, fetch the next one
        rd_word = w_inc;
        if (!uw_flags.full) begin
          word_nxt  = rd_sel;
          bit_nxt   = uw_low;
          state_nxt = S_SET;
        end else if (w_inc >= used_sel) begin
          status_nxt = bsa_pkg::ST_FULL;
          state_nxt  = S_RESP;
        end else begin
          w_nxt = w_inc;
        end
      end
      S_SET: begin
        // Mark the slot, move the hint, form the slot number
        uw_word    = word_r;
        wr_data    = uw_set;
        blk_we     = !pool_r;
        ino_we     = pool_r;
        status_nxt = bsa_pkg::ST_OK;
        slot_nxt   = SW'(w_r * WORD_BITS + bit_r);
        if (pool_r) begin
          inode_hint_nxt = w_r[IAW-1:0];
        end else begin
          block_hint_nxt = w_r[BAW-1:0];
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        // Load the output register once it is free
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_status_nxt = status_r;
          out_slot_nxt   = slot_r;
          out_is_set_nxt = is_set_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      block_hint_r <= '0;
      inode_hint_r <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      block_hint_r <= block_hint_nxt;
      inode_hint_r <= inode_hint_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_used_r <= bsa_pkg::BLOCK_USED_RST;
      inode_used_r <= bsa_pkg::INODE_USED_RST;
    end else if (cfg_we) begin
      if (cfg_addr == bsa_pkg::CFG_BLOCK_WORDS_USED) begin
        block_used_r <= cfg_wdata;
      end
      if (cfg_addr == bsa_pkg::CFG_INODE_WORDS_USED) begin
        inode_used_r <= cfg_wdata[bsa_pkg::INODE_USED_W-1:0];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    pool_r       <= pool_nxt;
    idx_r        <= idx_nxt;
    q_r          <= q_nxt;
    w_r          <= w_nxt;
    bit_r        <= bit_nxt;
    word_r       <= word_nxt;
    status_r     <= status_nxt;
    slot_r       <= slot_nxt;
    is_set_r     <= is_set_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_is_set_r <= out_is_set_nxt;
  end

endmodule

`default_nettype wire

@@ hdl/bsa_checker.sv @@
// Port-level checker of the slot allocator and its bind to the top level.
// Depends on bsa_pkg and bitmap_slot_allocator_defines.svh.
`default_nettype none

`include "bitmap_slot_allocator_defines.svh"

module bsa_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic [bsa_pkg::IN_TUSER_W-1:0]  in_tuser,
  input wire logic [bsa_pkg::IN_TDATA_W-1:0]  in_tdata,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [bsa_pkg::OUT_TUSER_W-1:0] out_tuser,
  input wire logic [bsa_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready
);

  logic in_beat;

  assign in_beat = in_tvalid && in_tready && (in_tuser == in_tuser) && (in_tdata == in_tdata);

  // A stalled result beat holds
  `BSA_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result beat changed while stalled")

  // One request at a time: busy right after a request beat
  `BSA_ASSERT_NXT(a_busy_after_req, clk, rst_n, in_beat, !in_tready, "request taken while busy")

  // A failed request carries no slot and no hit
  `BSA_ASSERT_NOW(a_fail_zero, clk, rst_n, out_tvalid && out_tuser != bsa_pkg::ST_OK, out_tdata == '0, "failed result carries data")

  // A hit only comes from a query, which grants no slot
  `BSA_ASSERT_NOW(a_hit_clean, clk, rst_n, out_tvalid && out_tdata[14], out_tuser == bsa_pkg::ST_OK && out_tdata[13:0] == '0, "query hit with bad status or slot")

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tuser   (in_tuser),
  .in_tdata   (in_tdata),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire
